// ===== sv/ppfc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppfc_pkg
// Shared types, constants and helpers for the per-peer credit flow control.
// ----------------------------------------------------------------------------
package ppfc_pkg;

  localparam int NUM_PEERS = 16;
  localparam int PEER_W    = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;

  localparam int OP_W     = 3;
  localparam int NODE_W   = 4;
  localparam int LEN_W    = 16;
  localparam int CNT_W    = 24;
  localparam int HO_W     = 10;
  localparam int COST_W   = 18;
  localparam int ADD_W    = 17;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SELF_NODE       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_OVERHEAD = 1'b1;

  localparam int BUF_BYTES = 'hC000;
  localparam int HDR_RESET = 220;
  localparam int HDR_WORDS = 2;

  localparam logic [CNT_W-1:0] CNT_MAX    = '1;
  localparam logic [CNT_W-1:0] SPEND_INIT =
    CNT_W'(BUF_BYTES - 2 * (HDR_RESET + HDR_WORDS * 8));
  localparam logic [HO_W-1:0]  HO_INIT    = HO_W'(HDR_RESET);

  localparam logic EMIT_REQUEST = 1'b0;
  localparam logic EMIT_GRANT   = 1'b1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE = 3'd0,
    OP_STAMP   = 3'd1,
    OP_MSG     = 3'd2,
    OP_CRED    = 3'd3,
    OP_REQ     = 3'd4,
    OP_DATA    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    CLS_NOP     = 3'd0,
    CLS_SELF    = 3'd1,
    CLS_RESERVE = 3'd2,
    CLS_STAMP   = 3'd3,
    CLS_MSG     = 3'd4,
    CLS_CRED    = 3'd5,
    CLS_REQ     = 3'd6,
    CLS_DATA    = 3'd7
  } cls_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EXEC = 2'b10
  } back_state_t;

  typedef struct packed {
    cls_t              cls;
    logic [PEER_W-1:0] peer;
    logic [COST_W-1:0] cost;
    logic [CNT_W-1:0]  cred;
    logic [ADD_W-1:0]  add;
  } q_entry_t;

  typedef struct packed {
    logic             granted;
    logic             blocked;
    logic             emit_valid;
    logic             emit_kind;
    logic [CNT_W-1:0] emit_credits;
    logic             wake;
    logic [CNT_W-1:0] piggyback_credits;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

// ===== sv/ppfc_in_if.sv =====
// ----------------------------------------------------------------------------
// ppfc_in_if
// Request channel into the credit flow control block.
// ----------------------------------------------------------------------------
interface ppfc_in_if;
  import ppfc_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [NODE_W-1:0] peer;
  logic [LEN_W-1:0]  first_len;
  logic [LEN_W-1:0]  rest_len;
  logic              multi;
  logic [CNT_W-1:0]  credits_in;
  logic [LEN_W-1:0]  recv_len;

  modport source (
    output valid, op, peer, first_len, rest_len, multi, credits_in, recv_len,
    input  ready
  );

  modport sink (
    input  valid, op, peer, first_len, rest_len, multi, credits_in, recv_len,
    output ready
  );
endinterface

// ===== sv/ppfc_out_if.sv =====
// ----------------------------------------------------------------------------
// ppfc_out_if
// Result channel out of the credit flow control block.
// ----------------------------------------------------------------------------
interface ppfc_out_if;
  import ppfc_pkg::*;

  logic             valid;
  logic             ready;
  logic             granted;
  logic             blocked;
  logic             emit_valid;
  logic             emit_kind;
  logic [CNT_W-1:0] emit_credits;
  logic             wake;
  logic [CNT_W-1:0] piggyback_credits;

  modport source (
    output valid, granted, blocked, emit_valid, emit_kind, emit_credits, wake,
           piggyback_credits,
    input  ready
  );

  modport sink (
    input  valid, granted, blocked, emit_valid, emit_kind, emit_credits, wake,
           piggyback_credits,
    output ready
  );
endinterface

// ===== sv/ppfc_front.sv =====
// ----------------------------------------------------------------------------
// ppfc_front
// Holds the configuration and classifies each request into a queue entry.
// ----------------------------------------------------------------------------
module ppfc_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ppfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppfc_pkg::CFG_DATA_W-1:0]    cfg_data,
  ppfc_in_if.sink                            in_ch,
  output logic                               q_wr_valid,
  output ppfc_pkg::q_entry_t                 q_wr_entry,
  input  logic                               q_wr_ready
);
  import ppfc_pkg::*;

  logic [NODE_W-1:0] self_node;
  logic [HO_W-1:0]   header_overhead;
  logic              in_range;
  logic [COST_W-1:0] cost_first;
  logic [COST_W-1:0] cost_rest;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_node       <= '0;
      header_overhead <= HO_INIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SELF_NODE:       self_node       <= cfg_data[NODE_W-1:0];
        CFG_HEADER_OVERHEAD: header_overhead <= cfg_data[HO_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_range   = 32'(in_ch.peer) < NUM_PEERS;
  assign cost_first = COST_W'(header_overhead) + COST_W'(in_ch.first_len);
  assign cost_rest  = in_ch.multi ?
                      COST_W'(header_overhead) + COST_W'(in_ch.rest_len) : '0;

  always_comb begin
    q_wr_entry.peer = PEER_W'(in_ch.peer);
    q_wr_entry.cost = cost_first + cost_rest;
    q_wr_entry.cred = in_ch.credits_in;
    q_wr_entry.add  = ADD_W'(header_overhead) + ADD_W'(in_ch.recv_len);
    q_wr_entry.cls  = CLS_NOP;
    case (op_t'(in_ch.op))
      OP_RESERVE: begin
        if (in_ch.peer == self_node) begin
          q_wr_entry.cls = CLS_SELF;
        end else if (in_range) begin
          q_wr_entry.cls = CLS_RESERVE;
        end
      end
      OP_STAMP: if (in_range) q_wr_entry.cls = CLS_STAMP;
      OP_MSG:   if (in_range) q_wr_entry.cls = CLS_MSG;
      OP_CRED:  if (in_range) q_wr_entry.cls = CLS_CRED;
      OP_REQ:   if (in_range) q_wr_entry.cls = CLS_REQ;
      OP_DATA:  q_wr_entry.cls = CLS_DATA;
      default:  q_wr_entry.cls = CLS_NOP;
    endcase
  end

  assign q_wr_valid  = in_ch.valid;
  assign in_ch.ready = q_wr_ready;

endmodule

// ===== sv/ppfc_queue.sv =====
// ----------------------------------------------------------------------------
// ppfc_queue
// Short FIFO of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module ppfc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  input  ppfc_pkg::q_entry_t wr_entry,
  output logic               wr_ready,
  output logic               rd_valid,
  output ppfc_pkg::q_entry_t rd_entry,
  input  logic               rd_ready
);
  import ppfc_pkg::*;

  q_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign wr_ready = count != QCNT_W'(QDEPTH);
  assign rd_valid = count != '0;
  assign rd_entry = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

// ===== sv/ppfc_back.sv =====
// ----------------------------------------------------------------------------
// ppfc_back
// Per-peer credit state: reads one peer entry, updates it, registers the result.
// ----------------------------------------------------------------------------
module ppfc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ppfc_pkg::q_entry_t q_entry,
  output logic               q_ready,
  ppfc_out_if.source         out_ch
);
  import ppfc_pkg::*;

  logic [CNT_W-1:0]  spendable [NUM_PEERS];
  logic [CNT_W-1:0]  owed_back [NUM_PEERS];
  logic [CNT_W-1:0]  shortfall [NUM_PEERS];
  logic              request_pending;
  logic [PEER_W-1:0] last_sender;

  back_state_t       state;
  q_entry_t          cur;
  logic [PEER_W-1:0] idx;
  logic [CNT_W-1:0]  rd_spend;
  logic [CNT_W-1:0]  rd_owed;
  logic [CNT_W-1:0]  rd_short;

  logic              res_valid;
  res_t              res;

  logic [PEER_W-1:0] load_idx;
  logic              exec_go;
  logic [CNT_W-1:0]  spend_add;
  logic [CNT_W-1:0]  owed_add;
  logic [CNT_W-1:0]  cost;
  logic              wake_ok;
  logic [CNT_W-1:0]  spend_next;
  logic [CNT_W-1:0]  owed_next;
  logic [CNT_W-1:0]  short_next;
  logic              request_pending_next;
  logic [PEER_W-1:0] last_sender_next;
  res_t              res_next;

  assign q_ready  = state == ST_LOAD;
  assign load_idx = (q_entry.cls == CLS_DATA) ? last_sender : q_entry.peer;
  assign exec_go  = (state == ST_EXEC) && (!res_valid || out_ch.ready);

  assign spend_add = sat_add(rd_spend, cur.cred);
  assign owed_add  = sat_add(rd_owed, CNT_W'(cur.add));
  assign cost      = CNT_W'(cur.cost);
  assign wake_ok   = (rd_short != '0) && (spend_add >= rd_short);

  always_comb begin
    spend_next           = rd_spend;
    owed_next            = rd_owed;
    short_next           = rd_short;
    request_pending_next = request_pending;
    last_sender_next     = last_sender;
    res_next             = '0;
    case (cur.cls)
      CLS_SELF: begin
        res_next.granted = 1'b1;
      end
      CLS_RESERVE: begin
        if (rd_spend < cost) begin
          short_next       = cost - rd_spend;
          spend_next       = '0;
          res_next.blocked = 1'b1;
          if (!request_pending) begin
            res_next.emit_valid   = 1'b1;
            res_next.emit_kind    = EMIT_REQUEST;
            res_next.emit_credits = rd_owed;
            owed_next             = '0;
            request_pending_next  = 1'b1;
          end
        end else begin
          spend_next       = rd_spend - cost;
          res_next.granted = 1'b1;
        end
      end
      CLS_STAMP: begin
        res_next.piggyback_credits = rd_owed;
        owed_next                  = '0;
      end
      CLS_MSG: begin
        owed_next        = owed_add;
        last_sender_next = cur.peer;
        spend_next       = wake_ok ? spend_add - rd_short : spend_add;
        short_next       = wake_ok ? '0 : rd_short;
        res_next.wake    = wake_ok;
      end
      CLS_CRED: begin
        request_pending_next = 1'b0;
        spend_next           = spend_add;
        if (rd_short != '0) begin
          if (wake_ok) begin
            spend_next    = spend_add - rd_short;
            short_next    = '0;
            res_next.wake = 1'b1;
          end else begin
            res_next.emit_valid   = 1'b1;
            res_next.emit_kind    = EMIT_REQUEST;
            res_next.emit_credits = rd_owed;
            owed_next             = '0;
            request_pending_next  = 1'b1;
          end
        end
      end
      CLS_REQ: begin
        res_next.emit_valid   = 1'b1;
        res_next.emit_kind    = EMIT_GRANT;
        res_next.emit_credits = rd_owed;
        owed_next             = '0;
        spend_next            = wake_ok ? spend_add - rd_short : spend_add;
        short_next            = wake_ok ? '0 : rd_short;
        res_next.wake         = wake_ok;
      end
      CLS_DATA: begin
        owed_next = owed_add;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PEERS; i++) begin
        spendable[i] <= SPEND_INIT;
        owed_back[i] <= '0;
        shortfall[i] <= '0;
      end
      request_pending <= 1'b0;
      last_sender     <= '0;
      state           <= ST_LOAD;
      res_valid       <= 1'b0;
    end else begin
      if (exec_go) begin
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (q_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            spendable[idx]  <= spend_next;
            owed_back[idx]  <= owed_next;
            shortfall[idx]  <= short_next;
            request_pending <= request_pending_next;
            last_sender     <= last_sender_next;
            state           <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && q_valid) begin
      cur      <= q_entry;
      idx      <= load_idx;
      rd_spend <= spendable[load_idx];
      rd_owed  <= owed_back[load_idx];
      rd_short <= shortfall[load_idx];
    end
    if (exec_go) begin
      res <= res_next;
    end
  end

  assign out_ch.valid             = res_valid;
  assign out_ch.granted           = res.granted;
  assign out_ch.blocked           = res.blocked;
  assign out_ch.emit_valid        = res.emit_valid;
  assign out_ch.emit_kind         = res.emit_kind;
  assign out_ch.emit_credits      = res.emit_credits;
  assign out_ch.wake              = res.wake;
  assign out_ch.piggyback_credits = res.piggyback_credits;

endmodule

// ===== sv/per_peer_credit_flow_control_core.sv =====
// ----------------------------------------------------------------------------
// per_peer_credit_flow_control_core
// Per-peer byte credit accounting: grants or blocks sends, emits request and
// grant headers, and wakes blocked senders.
// ----------------------------------------------------------------------------
// An accepted request is queued, loaded into the back part, and its result is
// registered. The back part reads, then updates, a peer's credit entry and
// takes no new request before that update, which an unread result holds off.
// Reset: synchronous; every peer starts with 48680 spendable credits, nothing
// owed, no shortfall, and the configuration returns to its reset values.
module per_peer_credit_flow_control_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ppfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppfc_pkg::CFG_DATA_W-1:0] cfg_data,
  ppfc_in_if.sink                         in_ch,
  ppfc_out_if.source                      out_ch
);
  import ppfc_pkg::*;

  logic     q_wr_valid;
  logic     q_wr_ready;
  q_entry_t q_wr_entry;
  logic     q_rd_valid;
  logic     q_rd_ready;
  q_entry_t q_rd_entry;

  ppfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .q_wr_valid (q_wr_valid),
    .q_wr_entry (q_wr_entry),
    .q_wr_ready (q_wr_ready)
  );

  ppfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_entry (q_wr_entry),
    .wr_ready (q_wr_ready),
    .rd_valid (q_rd_valid),
    .rd_entry (q_rd_entry),
    .rd_ready (q_rd_ready)
  );

  ppfc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_rd_valid),
    .q_entry (q_rd_entry),
    .q_ready (q_rd_ready),
    .out_ch  (out_ch)
  );

  a_queue_holds_accepted: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> q_rd_valid)
    else $error("accepted request did not reach the queue");

  a_no_grant_and_block: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.granted && out_ch.blocked))
    else $error("result both granted and blocked");

  a_quiet_header_fields: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.emit_valid) |->
      (out_ch.emit_kind == EMIT_REQUEST && out_ch.emit_credits == '0))
    else $error("header fields set without an emitted header");

  a_grant_only_with_wake_free: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.emit_valid && out_ch.emit_kind == EMIT_REQUEST) |->
      !out_ch.granted && !out_ch.wake)
    else $error("request header emitted alongside a grant or wake");

endmodule

// ===== sim/tb_per_peer_credit_flow_control_core.sv =====
// ----------------------------------------------------------------------------
// tb_per_peer_credit_flow_control_core
// Self-checking bench for the per-peer credit flow control core. A short
// directed sequence covers reset values, field extremes, every operation,
// self sends, unused op codes and saturation. Randomized phases under several
// register settings follow, with random idling on both channels and one long
// result back-pressure. Every result is compared field by field, with fixed
// values for some directed rows, else an in-bench model of credit accounting.
// ----------------------------------------------------------------------------
module tb_per_peer_credit_flow_control_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ppfc_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 76;
  localparam int NUM_PHASES   = 5;
  localparam int DRAIN_CYCLES = 8;

  localparam res_t RES_IDLE    = '0;
  localparam res_t RES_GRANTED = '{granted: 1'b1, default: '0};

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] peer;
    logic [LEN_W-1:0]  first_len;
    logic [LEN_W-1:0]  rest_len;
    logic              multi;
    logic [CNT_W-1:0]  credits_in;
    logic [LEN_W-1:0]  recv_len;
  } req_t;

  typedef struct {
    req_t rq;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ppfc_in_if  in_ch ();
  ppfc_out_if out_ch ();

  per_peer_credit_flow_control_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Credit state as the block should hold it.
  logic [CNT_W-1:0]  spend_cr [NUM_PEERS];
  logic [CNT_W-1:0]  owed_cr  [NUM_PEERS];
  logic [CNT_W-1:0]  short_cr [NUM_PEERS];
  logic              req_out;
  logic [NODE_W-1:0] last_src;
  logic [NODE_W-1:0] self_id;
  logic [HO_W-1:0]   hdr_bytes;

  res_t pending_results[$];
  int   errors       = 0;
  int   quiet_cycles = 0;
  int   rx_hold      = 0;
  int   rx_gap       = 0;
  bit   tx_idle      = 1'b1;
  bit   rx_idle      = 1'b1;

  always #5 clk = ~clk;

  function automatic logic [CNT_W-1:0] credit_sum(input logic [CNT_W-1:0] a,
                                                  input logic [31:0] b);
    logic [31:0] s;
    s = 32'(a) + b;
    return (s > 32'(CNT_MAX)) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < NUM_PEERS; i++) begin
      spend_cr[i] = SPEND_INIT;
      owed_cr[i]  = '0;
      short_cr[i] = '0;
    end
    req_out   = 1'b0;
    last_src  = '0;
    self_id   = '0;
    hdr_bytes = HO_INIT;
  endfunction

  function automatic logic release_waiter(input int p);
    if (short_cr[p] != '0 && spend_cr[p] >= short_cr[p]) begin
      spend_cr[p] = spend_cr[p] - short_cr[p];
      short_cr[p] = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void send_header(input int p, input logic kind, inout res_t r);
    r.emit_valid   = 1'b1;
    r.emit_kind    = kind;
    r.emit_credits = owed_cr[p];
    owed_cr[p]     = '0;
  endfunction

  function automatic res_t apply_request(input req_t rq);
    res_t        r;
    int          p;
    logic [31:0] cost;
    r = '0;
    p = int'(rq.peer);
    if (rq.op == OP_RESERVE && rq.peer == self_id) begin
      r.granted = 1'b1;
      return r;
    end
    case (rq.op)
      OP_RESERVE: begin
        cost = 32'(hdr_bytes) + 32'(rq.first_len);
        if (rq.multi) cost = cost + 32'(hdr_bytes) + 32'(rq.rest_len);
        if (cost > 32'(CNT_MAX)) cost = 32'(CNT_MAX);
        if (32'(spend_cr[p]) < cost) begin
          short_cr[p] = CNT_W'(cost - 32'(spend_cr[p]));
          spend_cr[p] = '0;
          r.blocked   = 1'b1;
          if (!req_out) begin
            send_header(p, EMIT_REQUEST, r);
            req_out = 1'b1;
          end
        end else begin
          spend_cr[p] = CNT_W'(32'(spend_cr[p]) - cost);
          r.granted   = 1'b1;
        end
      end
      OP_STAMP: begin
        r.piggyback_credits = owed_cr[p];
        owed_cr[p]          = '0;
      end
      OP_MSG: begin
        spend_cr[p] = credit_sum(spend_cr[p], 32'(rq.credits_in));
        owed_cr[p]  = credit_sum(owed_cr[p], 32'(hdr_bytes) + 32'(rq.recv_len));
        r.wake      = release_waiter(p);
        last_src    = rq.peer;
      end
      OP_CRED: begin
        req_out     = 1'b0;
        spend_cr[p] = credit_sum(spend_cr[p], 32'(rq.credits_in));
        if (short_cr[p] != '0) begin
          if (spend_cr[p] >= short_cr[p]) begin
            r.wake = release_waiter(p);
          end else begin
            send_header(p, EMIT_REQUEST, r);
            req_out = 1'b1;
          end
        end
      end
      OP_REQ: begin
        spend_cr[p] = credit_sum(spend_cr[p], 32'(rq.credits_in));
        send_header(p, EMIT_GRANT, r);
        r.wake = release_waiter(p);
      end
      OP_DATA: begin
        owed_cr[last_src] = credit_sum(owed_cr[last_src],
                                       32'(hdr_bytes) + 32'(rq.recv_len));
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic dir_row_t row(input logic [OP_W-1:0] op, input int peer,
                                   input int fl, input int rl, input bit m,
                                   input int cr, input int rv,
                                   input bit typed = 1'b0,
                                   input res_t want = '0);
    dir_row_t d;
    d.rq.op         = op;
    d.rq.peer       = NODE_W'(peer);
    d.rq.first_len  = LEN_W'(fl);
    d.rq.rest_len   = LEN_W'(rl);
    d.rq.multi      = m;
    d.rq.credits_in = CNT_W'(cr);
    d.rq.recv_len   = LEN_W'(rv);
    d.typed         = typed;
    d.want          = want;
    return d;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 5))
      0, 1, 2: return LEN_W'($urandom_range(0, 4000));
      3:       return LEN_W'($urandom);
      4:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic req_t random_request();
    req_t rq;
    int   k;
    k = $urandom_range(0, 99);
    if (k < 30)      rq.op = OP_RESERVE;
    else if (k < 40) rq.op = OP_STAMP;
    else if (k < 60) rq.op = OP_MSG;
    else if (k < 75) rq.op = OP_CRED;
    else if (k < 85) rq.op = OP_REQ;
    else if (k < 95) rq.op = OP_DATA;
    else             rq.op = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
    rq.peer = ($urandom_range(0, 3) == 0) ? NODE_W'($urandom_range(0, 15))
                                          : NODE_W'($urandom_range(0, 3));
    rq.first_len = pick_len();
    rq.rest_len  = pick_len();
    rq.multi     = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0, 1, 2, 3: rq.credits_in = CNT_W'($urandom_range(0, 30000));
      4, 5:       rq.credits_in = CNT_W'($urandom);
      6:          rq.credits_in = '0;
      default:    rq.credits_in = CNT_MAX;
    endcase
    rq.recv_len = LEN_W'($urandom);
    return rq;
  endfunction

  task automatic send_item(input req_t rq, input bit typed, input res_t want);
    res_t r;
    @(negedge clk);
    in_ch.op         = rq.op;
    in_ch.peer       = rq.peer;
    in_ch.first_len  = rq.first_len;
    in_ch.rest_len   = rq.rest_len;
    in_ch.multi      = rq.multi;
    in_ch.credits_in = rq.credits_in;
    in_ch.recv_len   = rq.recv_len;
    in_ch.valid      = 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    r = apply_request(rq);
    pending_results.push_back(typed ? want : r);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_config(input logic [NODE_W-1:0] node, input logic [HO_W-1:0] ovh);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_SELF_NODE;
    cfg_data  = CFG_DATA_W'(node);
    @(negedge clk);
    cfg_index = CFG_HEADER_OVERHEAD;
    cfg_data  = CFG_DATA_W'(ovh);
    @(negedge clk);
    cfg_we    = 1'b0;
    self_id   = node;
    hdr_bytes = ovh;
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      $error("result with no request outstanding");
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.granted !== want.granted) begin
      $error("granted: expected %0d, got %0d", want.granted, got.granted);
      errors++;
    end
    if (got.blocked !== want.blocked) begin
      $error("blocked: expected %0d, got %0d", want.blocked, got.blocked);
      errors++;
    end
    if (got.emit_valid !== want.emit_valid) begin
      $error("emit_valid: expected %0d, got %0d", want.emit_valid, got.emit_valid);
      errors++;
    end
    if (got.emit_kind !== want.emit_kind) begin
      $error("emit_kind: expected %0d, got %0d", want.emit_kind, got.emit_kind);
      errors++;
    end
    if (got.emit_credits !== want.emit_credits) begin
      $error("emit_credits: expected %0d, got %0d", want.emit_credits, got.emit_credits);
      errors++;
    end
    if (got.wake !== want.wake) begin
      $error("wake: expected %0d, got %0d", want.wake, got.wake);
      errors++;
    end
    if (got.piggyback_credits !== want.piggyback_credits) begin
      $error("piggyback_credits: expected %0d, got %0d", want.piggyback_credits,
             got.piggyback_credits);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    res_t got;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.granted           = out_ch.granted;
      got.blocked           = out_ch.blocked;
      got.emit_valid        = out_ch.emit_valid;
      got.emit_kind         = out_ch.emit_kind;
      got.emit_credits      = out_ch.emit_credits;
      got.wake              = out_ch.wake;
      got.piggyback_credits = out_ch.piggyback_credits;
      check_result(got);
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : result_ready
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ch.ready = 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        out_ch.ready = 1'b0;
        rx_gap--;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        rx_gap       = $urandom_range(0, 6);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  initial begin : stimulus
    dir_row_t          rows[$];
    logic [NODE_W-1:0] node_set [NUM_PHASES];
    logic [HO_W-1:0]   ovh_set  [NUM_PHASES];
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_RESERVE;
    in_ch.peer       = '0;
    in_ch.first_len  = '0;
    in_ch.rest_len   = '0;
    in_ch.multi      = 1'b0;
    in_ch.credits_in = '0;
    in_ch.recv_len   = '0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_SELF_NODE;
    cfg_data         = '0;
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    rows.push_back(row(OP_RESERVE, 1, 0, 0, 0, 0, 0, 1, RES_GRANTED));
    rows.push_back(row(OP_RESERVE, 0, 'hFFFF, 'hFFFF, 1, 0, 0, 1, RES_GRANTED));
    rows.push_back(row(OP_SPARE_A, 15, 'hFFFF, 'hFFFF, 1, 'hFFFFFF, 'hFFFF, 1, RES_IDLE));
    rows.push_back(row(OP_SPARE_B, 3, 'hFFFF, 'hFFFF, 1, 'hFFFFFF, 'hFFFF, 1, RES_IDLE));
    rows.push_back(row(OP_STAMP, 1, 0, 0, 0, 0, 0, 1, RES_IDLE));
    rows.push_back(row(OP_MSG, 2, 0, 0, 0, 0, 0, 1, RES_IDLE));
    rows.push_back(row(OP_DATA, 15, 0, 0, 0, 0, 'hFFFF, 1, RES_IDLE));
    rows.push_back(row(OP_STAMP, 2, 0, 0, 0, 0, 0));
    rows.push_back(row(OP_RESERVE, 3, 'hFFFF, 'hFFFF, 1, 0, 0));
    rows.push_back(row(OP_RESERVE, 4, 'hFFFF, 0, 0, 0, 0));
    rows.push_back(row(OP_CRED, 3, 0, 0, 0, 100, 0));
    rows.push_back(row(OP_CRED, 3, 0, 0, 0, 'hFFFFFF, 0));
    rows.push_back(row(OP_REQ, 4, 0, 0, 0, 'hFFFFFF, 0));
    rows.push_back(row(OP_MSG, 5, 0, 0, 0, 'hFFFFFF, 'hFFFF));
    rows.push_back(row(OP_RESERVE, 5, 0, 'hFFFF, 0, 0, 0));
    rows.push_back(row(OP_RESERVE, 15, 'hFFFF, 0, 0, 0, 0));
    rows.push_back(row(OP_MSG, 15, 0, 0, 0, 20000, 100));
    rows.push_back(row(OP_DATA, 0, 0, 0, 0, 0, 1234));
    rows.push_back(row(OP_REQ, 15, 0, 0, 0, 0, 0));
    rows.push_back(row(OP_STAMP, 15, 0, 0, 0, 0, 0));
    rows.push_back(row(OP_CRED, 6, 0, 0, 0, 5, 0));
    foreach (rows[i]) send_item(rows[i].rq, rows[i].typed, rows[i].want);
    drain_results();

    node_set = '{4'd0, 4'd15, 4'd5, NODE_W'($urandom), 4'd3};
    ovh_set  = '{10'd220, 10'd1023, 10'd0, HO_W'($urandom), 10'd512};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      tx_idle = (ph < NUM_PHASES - 1);
      rx_idle = (ph < NUM_PHASES - 1);
      load_config(node_set[ph], ovh_set[ph]);
      // Hold results off long enough for the core to fill and stall its input.
      if (ph == 1) rx_hold = HOLD_CYCLES;
      repeat (PHASE_ITEMS) send_item(random_request(), 1'b0, RES_IDLE);
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ppfc_pkg.sv
sv/ppfc_in_if.sv
sv/ppfc_out_if.sv
sv/ppfc_front.sv
sv/ppfc_queue.sv
sv/ppfc_back.sv
sv/per_peer_credit_flow_control_core.sv
sim/tb_per_peer_credit_flow_control_core.sv
